// ===== hw/rtl/sac_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_pkg: shared types and constants of the set-associative tag store
// Register map codes, reset values, sequencer states and the status group
// that the way scan unit hands back to the top level.
// ----------------------------------------------------------------------------
package sac_pkg;

  // access address width, fixed by the 32-bit address field
  localparam int unsigned ADDR_BITS      = 32;
  localparam int unsigned MIN_INDEX_BITS = 3;

  // configuration port
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  localparam logic [1:0] REG_INDEX_BITS = 2'd0;
  localparam logic [1:0] REG_WAYS       = 2'd1;
  localparam logic [1:0] REG_POLICY     = 2'd2;

  localparam logic [3:0] INDEX_BITS_RST = 4'd6;
  localparam logic [3:0] WAYS_RST       = 4'd1;

  localparam logic POLICY_LRU  = 1'b0;
  localparam logic POLICY_FIFO = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD,
    ST_OUT
  } sac_state_e;

  // status of the way scan
  typedef struct packed {
    logic last;      // current way is the last one
    logic hit;       // tag matched a valid way
    logic old_vld;   // at least one valid way seen, oldest tracked
    logic free_vld;  // an invalid way was seen
  } scan_t;

endpackage

// ===== hw/rtl/sac_way_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_way_scan: tag compare and age search, one way per cycle while step_i is high
// Steps through the ways of a fetched set row with a single comparator and
// collects hit way, oldest valid way, first free way and the valid count.
// ----------------------------------------------------------------------------
module sac_way_scan #(
  parameter int unsigned MAX_WAYS = 8,
  parameter int unsigned TAG_W    = 25,
  parameter int unsigned AGE_W    = 3,
  parameter int unsigned WAY_W    = 3,
  parameter int unsigned CNT_W    = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              step_i,
  input  logic [TAG_W-1:0]                  lookup_tag_i,
  input  logic [MAX_WAYS-1:0][TAG_W-1:0]    row_tag_i,
  input  logic [MAX_WAYS-1:0][AGE_W-1:0]    row_age_i,
  input  logic [MAX_WAYS-1:0]               row_vld_i,
  output sac_pkg::scan_t                    scan_o,
  output logic [WAY_W-1:0]                  hit_way_o,
  output logic [AGE_W-1:0]                  hit_age_o,
  output logic [WAY_W-1:0]                  old_way_o,
  output logic [WAY_W-1:0]                  free_way_o,
  output logic [CNT_W-1:0]                  count_o
);

  logic [WAY_W-1:0] way_q;
  logic             last;
  logic             cur_vld;
  logic [TAG_W-1:0] cur_tag;
  logic [AGE_W-1:0] cur_age;
  logic             tag_eq;

  logic             hit_q, hit_d;
  logic [WAY_W-1:0] hit_way_q, hit_way_d;
  logic [AGE_W-1:0] hit_age_q, hit_age_d;
  logic             old_vld_q, old_vld_d;
  logic [WAY_W-1:0] old_way_q, old_way_d;
  logic [AGE_W-1:0] old_age_q, old_age_d;
  logic             free_vld_q, free_vld_d;
  logic [WAY_W-1:0] free_way_q, free_way_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign last    = (way_q == WAY_W'(MAX_WAYS - 1));
  assign cur_vld = row_vld_i[way_q];
  assign cur_tag = row_tag_i[way_q];
  assign cur_age = row_age_i[way_q];
  assign tag_eq  = (cur_tag == lookup_tag_i);

  always_comb begin
    hit_d      = hit_q;
    hit_way_d  = hit_way_q;
    hit_age_d  = hit_age_q;
    old_vld_d  = old_vld_q;
    old_way_d  = old_way_q;
    old_age_d  = old_age_q;
    free_vld_d = free_vld_q;
    free_way_d = free_way_q;
    count_d    = count_q;
    if (cur_vld) begin
      count_d = count_q + CNT_W'(1);
      if (!hit_q && tag_eq) begin
        hit_d     = 1'b1;
        hit_way_d = way_q;
        hit_age_d = cur_age;
      end
      // strictly older wins, so ties keep the lowest way
      if (!old_vld_q || (cur_age > old_age_q)) begin
        old_vld_d = 1'b1;
        old_way_d = way_q;
        old_age_d = cur_age;
      end
    end else if (!free_vld_q) begin
      free_vld_d = 1'b1;
      free_way_d = way_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      way_q      <= '0;
      hit_q      <= 1'b0;
      old_vld_q  <= 1'b0;
      free_vld_q <= 1'b0;
      count_q    <= '0;
    end else if (start_i) begin
      way_q      <= '0;
      hit_q      <= 1'b0;
      old_vld_q  <= 1'b0;
      free_vld_q <= 1'b0;
      count_q    <= '0;
    end else if (step_i) begin
      if (!last) begin
        way_q <= way_q + WAY_W'(1);
      end
      hit_q      <= hit_d;
      old_vld_q  <= old_vld_d;
      free_vld_q <= free_vld_d;
      count_q    <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && !start_i) begin
      hit_way_q  <= hit_way_d;
      hit_age_q  <= hit_age_d;
      old_way_q  <= old_way_d;
      old_age_q  <= old_age_d;
      free_way_q <= free_way_d;
    end
  end

  assign scan_o.last     = last;
  assign scan_o.hit      = hit_q;
  assign scan_o.old_vld  = old_vld_q;
  assign scan_o.free_vld = free_vld_q;
  assign hit_way_o       = hit_way_q;
  assign hit_age_o       = hit_age_q;
  assign old_way_o       = old_way_q;
  assign free_way_o      = free_way_q;
  assign count_o         = count_q;

endmodule

// ===== hw/rtl/set_assoc_cache_hit_miss.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_hit_miss: tag store of a set-associative cache
// Flow: an accepted address fetches its set row, ST_SCAN visits one way per
//   cycle with the single tag comparator, ST_UPD writes the row back and
//   ST_OUT loads the result when the output is free; items enter in ST_IDLE.
// Reset: registers go to their reset values, then a clearing pass over all
//   MAX_SETS sets wipes valid bits and ages; no item is taken meanwhile.
// ----------------------------------------------------------------------------
module set_assoc_cache_hit_miss #(
  parameter int unsigned MAX_SETS    = 1024,
  parameter int unsigned MAX_WAYS    = 8,
  parameter int unsigned OFFSET_BITS = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input items
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [31:0]                 s_axis_tdata,   // [31:0] address
  // result items
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [39:0]                 m_axis_tdata,   // [0] hit, [1] evicted,
                                                      // [33:2] miss_total
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sac_pkg::APB_AW-1:0]  paddr,
  input  logic [sac_pkg::APB_DW-1:0]  pwdata,
  output logic [sac_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int unsigned SET_W = $clog2(MAX_SETS);
  localparam int unsigned BLK_W = sac_pkg::ADDR_BITS - OFFSET_BITS;
  localparam int unsigned TAG_W = BLK_W - sac_pkg::MIN_INDEX_BITS;
  localparam int unsigned WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned AGE_W = WAY_W;
  localparam int unsigned CNT_W = $clog2(MAX_WAYS + 1);
  localparam int unsigned CMP_W = (CNT_W > 5) ? CNT_W : 5;

  // ---------------- configuration registers ----------------
  logic [3:0] index_bits_q;
  logic [3:0] ways_q;
  logic       policy_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_bits_q <= sac_pkg::INDEX_BITS_RST;
      ways_q       <= sac_pkg::WAYS_RST;
      policy_q     <= sac_pkg::POLICY_LRU;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        sac_pkg::REG_INDEX_BITS: index_bits_q <= pwdata[3:0];
        sac_pkg::REG_WAYS:       ways_q       <= pwdata[3:0];
        sac_pkg::REG_POLICY:     policy_q     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      sac_pkg::REG_INDEX_BITS: prdata = {28'd0, index_bits_q};
      sac_pkg::REG_WAYS:       prdata = {28'd0, ways_q};
      sac_pkg::REG_POLICY:     prdata = {31'd0, policy_q};
      default:                 prdata = '0;
    endcase
  end

  // effective index width and associativity
  logic [3:0]       ib_eff;
  logic [CMP_W-1:0] ways_eff;

  always_comb begin
    ib_eff = index_bits_q;
    if (ib_eff < 4'(sac_pkg::MIN_INDEX_BITS)) begin
      ib_eff = 4'(sac_pkg::MIN_INDEX_BITS);
    end else if (ib_eff > 4'(SET_W)) begin
      ib_eff = 4'(SET_W);
    end
    ways_eff = CMP_W'(ways_q);
    if (ways_eff == '0) begin
      ways_eff = CMP_W'(1);
    end else if (ways_eff > CMP_W'(MAX_WAYS)) begin
      ways_eff = CMP_W'(MAX_WAYS);
    end
  end

  // ---------------- address split ----------------
  logic [BLK_W-1:0] in_blk;
  logic [BLK_W-1:0] in_blk_shr;
  logic [SET_W-1:0] in_set;
  logic [TAG_W-1:0] in_tag;

  assign in_blk     = s_axis_tdata[sac_pkg::ADDR_BITS-1:OFFSET_BITS];
  assign in_blk_shr = in_blk >> ib_eff;
  assign in_set     = in_blk[SET_W-1:0] & ~({SET_W{1'b1}} << ib_eff);
  assign in_tag     = in_blk_shr[TAG_W-1:0];

  // ---------------- sequencer ----------------
  sac_pkg::sac_state_e state_q, state_d;
  sac_pkg::scan_t      scan;

  logic clr_busy_q;
  logic [SET_W-1:0] clr_idx_q;
  logic rd_en, scan_step, mem_we, out_load;
  logic m_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sac_pkg::ST_IDLE: if (rd_en) state_d = sac_pkg::ST_SCAN;
      sac_pkg::ST_SCAN: if (scan.last) state_d = sac_pkg::ST_UPD;
      sac_pkg::ST_UPD:  state_d = sac_pkg::ST_OUT;
      sac_pkg::ST_OUT:  if (out_load) state_d = sac_pkg::ST_IDLE;
      default:          state_d = sac_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == sac_pkg::ST_IDLE) && !clr_busy_q;
    rd_en         = s_axis_tvalid && s_axis_tready;
    scan_step     = (state_q == sac_pkg::ST_SCAN);
    mem_we        = (state_q == sac_pkg::ST_UPD);
    out_load      = (state_q == sac_pkg::ST_OUT) && (!m_valid_q || m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= sac_pkg::ST_IDLE;
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else begin
      state_q <= state_d;
      if (clr_busy_q) begin
        clr_idx_q <= clr_idx_q + SET_W'(1);
        if (clr_idx_q == SET_W'(MAX_SETS - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
    end
  end

  // ---------------- set row memory ----------------
  logic [MAX_WAYS-1:0][TAG_W-1:0] tag_mem [MAX_SETS];
  logic [MAX_WAYS-1:0][AGE_W-1:0] age_mem [MAX_SETS];
  logic [MAX_WAYS-1:0]            vld_mem [MAX_SETS];

  logic [MAX_WAYS-1:0][TAG_W-1:0] row_tag_q, new_tag;
  logic [MAX_WAYS-1:0][AGE_W-1:0] row_age_q, new_age;
  logic [MAX_WAYS-1:0]            row_vld_q, new_vld;
  logic [SET_W-1:0]               set_q;
  logic [TAG_W-1:0]               tag_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tag_mem[set_q] <= new_tag;
      age_mem[set_q] <= new_age;
      vld_mem[set_q] <= new_vld;
    end else if (clr_busy_q) begin
      age_mem[clr_idx_q] <= '0;
      vld_mem[clr_idx_q] <= '0;
    end
    if (rd_en) begin
      row_tag_q <= tag_mem[in_set];
      row_age_q <= age_mem[in_set];
      row_vld_q <= vld_mem[in_set];
      set_q     <= in_set;
      tag_q     <= in_tag;
    end
  end

  // ---------------- way scan ----------------
  logic [WAY_W-1:0] hit_way, old_way, free_way;
  logic [AGE_W-1:0] hit_age;
  logic [CNT_W-1:0] count;

  sac_way_scan #(
    .MAX_WAYS (MAX_WAYS),
    .TAG_W    (TAG_W),
    .AGE_W    (AGE_W),
    .WAY_W    (WAY_W),
    .CNT_W    (CNT_W)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (rd_en),
    .step_i       (scan_step),
    .lookup_tag_i (tag_q),
    .row_tag_i    (row_tag_q),
    .row_age_i    (row_age_q),
    .row_vld_i    (row_vld_q),
    .scan_o       (scan),
    .hit_way_o    (hit_way),
    .hit_age_o    (hit_age),
    .old_way_o    (old_way),
    .free_way_o   (free_way),
    .count_o      (count)
  );

  // ---------------- row update ----------------
  logic             evict;
  logic             tgt_vld;
  logic [WAY_W-1:0] tgt_way;

  always_comb begin
    evict   = !scan.hit && (CMP_W'(count) >= ways_eff) && scan.old_vld;
    tgt_vld = !scan.hit && (evict || scan.free_vld);
    tgt_way = evict ? old_way : free_way;
    for (int w = 0; w < MAX_WAYS; w++) begin
      new_tag[w] = row_tag_q[w];
      new_age[w] = row_age_q[w];
      new_vld[w] = row_vld_q[w];
      if (scan.hit) begin
        if (policy_q == sac_pkg::POLICY_LRU) begin
          if (hit_way == WAY_W'(w)) begin
            new_age[w] = '0;
          end else if (row_vld_q[w] && (row_age_q[w] < hit_age)) begin
            new_age[w] = row_age_q[w] + AGE_W'(1);
          end
        end
      end else if (tgt_vld) begin
        // evicted or free target way is filled in place, all other valid ways age
        if (tgt_way == WAY_W'(w)) begin
          new_tag[w] = tag_q;
          new_age[w] = '0;
          new_vld[w] = 1'b1;
        end else if (row_vld_q[w]) begin
          new_age[w] = row_age_q[w] + AGE_W'(1);
        end
      end
    end
  end

  // ---------------- miss counter and result ----------------
  logic [31:0] miss_q;
  logic        res_hit_q;
  logic        res_evict_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      miss_q <= '0;
    end else if (mem_we && !scan.hit && (miss_q != '1)) begin
      miss_q <= miss_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      res_hit_q   <= scan.hit;
      res_evict_q <= evict;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_axis_tdata <= {6'd0, miss_q, res_evict_q, res_hit_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;

  // ---------------- assertions ----------------
  a_no_take_while_clearing: assert property (
    @(posedge clk_i) disable iff (!rst_ni) clr_busy_q |-> !s_axis_tready)
    else $error("item taken during clearing pass");

  a_scan_done_at_update: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (state_q == sac_pkg::ST_UPD) |-> scan.last)
    else $error("row update before all ways scanned");

  a_miss_count_only_on_miss: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (miss_q != $past(miss_q)) |-> ($past(mem_we) && !$past(scan.hit)))
    else $error("miss counter moved without a miss");

  a_hit_never_evicts: assert property (
    @(posedge clk_i) disable iff (!rst_ni) m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("hit and eviction reported together");

endmodule
